>>> hw/rtl/bresenham_line_pixel_gen_assert.svh
// Assertion macros for the line pixel generator checker.
// Clocked on clk_i, disabled while rst_ni is low; no other dependencies.
`ifndef BRESENHAM_LINE_PIXEL_GEN_ASSERT_SVH
`define BRESENHAM_LINE_PIXEL_GEN_ASSERT_SVH

// same-cycle implication
`define BLPG_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BLPG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/blpg_pkg.sv
// Shared types and constants for the line pixel generator.
// Used by blpg_walk, the top level and the port checker.
`default_nettype none

package blpg_pkg;

  localparam int unsigned CoordW   = 12;
  localparam int unsigned ColorW   = 16;
  localparam int unsigned DecW     = 14;
  localparam int unsigned AddrW    = 20;
  localparam int unsigned BankW    = 5;
  localparam int unsigned RowShift = 10;
  localparam int unsigned BankShift = 15;

  localparam logic CmdStart = 1'b0;
  localparam logic CmdStep  = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic signed [CoordW-1:0] x_start;
    logic signed [CoordW-1:0] y_start;
    logic signed [CoordW-1:0] x_end;
    logic signed [CoordW-1:0] y_end;
    logic [ColorW-1:0]        pen_color;
  } blpg_req_t;

  typedef struct packed {
    logic                     pixel_valid;
    logic signed [CoordW-1:0] pixel_x;
    logic signed [CoordW-1:0] pixel_y;
    logic [ColorW-1:0]        pixel_color;
    logic                     on_screen;
    logic [AddrW-1:0]         word_address;
    logic [BankW-1:0]         bank;
    logic                     bank_switch;
    logic                     last_pixel;
  } blpg_rsp_t;

  // pixel waiting between the walker and the output register
  typedef struct packed {
    logic                     valid;
    logic                     pix;
    logic                     last;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [ColorW-1:0]        color;
  } blpg_pend_t;

endpackage

`default_nettype wire

>>> hw/rtl/blpg_walk.sv
// Line walker: takes start and step requests and advances the Bresenham state.
// Depends on blpg_pkg; feeds one pending pixel to the top level.
`default_nettype none

module blpg_walk import blpg_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       req_valid_i,
  output logic            req_ready_o,
  input  wire blpg_req_t  req_i,
  input  wire logic       adv_i,
  output blpg_pend_t      pend_o
);

  logic                     active_q, active_d;
  logic signed [CoordW-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [DecW-1:0]   dec_q, dec_d;
  logic [CoordW-1:0]        steps_q, steps_d;
  logic signed [DecW-1:0]   minor_incr_q, minor_incr_d;
  logic signed [DecW-1:0]   diag_incr_q, diag_incr_d;
  logic                     x_major_q, x_major_d;
  logic                     x_neg_q, x_neg_d, y_neg_q, y_neg_d;
  logic [ColorW-1:0]        color_q, color_d;
  logic                     pend_valid_q, pend_valid_d;
  logic                     pend_pix_q, pend_pix_d;
  logic                     pend_last_q, pend_last_d;

  logic                     accept;
  logic signed [CoordW:0]   ex, ey;
  logic [CoordW-1:0]        dx, dy, maj, mnr;
  logic                     axis, xmaj;
  logic signed [CoordW-1:0] sx, sy;
  logic signed [DecW-1:0]   mnr2;
  logic                     minor_move;
  logic [CoordW-1:0]        xinc, yinc, steps_nxt;

  assign req_ready_o = !pend_valid_q || adv_i;
  assign accept      = req_valid_i && req_ready_o;

  // start setup
  always_comb begin
    ex   = {req_i.x_end[CoordW-1], req_i.x_end} - {req_i.x_start[CoordW-1], req_i.x_start};
    ey   = {req_i.y_end[CoordW-1], req_i.y_end} - {req_i.y_start[CoordW-1], req_i.y_start};
    dx   = ex[CoordW] ? CoordW'(-ex) : ex[CoordW-1:0];
    dy   = ey[CoordW] ? CoordW'(-ey) : ey[CoordW-1:0];
    axis = (dx == '0) || (dy == '0);
    sx   = (axis && ex[CoordW]) ? req_i.x_end : req_i.x_start;
    sy   = (axis && ey[CoordW]) ? req_i.y_end : req_i.y_start;
    xmaj = dx >= dy;
    maj  = xmaj ? dx : dy;
    mnr  = xmaj ? dy : dx;
    mnr2 = {1'b0, mnr, 1'b0};
  end

  // one step
  always_comb begin
    minor_move = !dec_q[DecW-1] && (dec_q != '0);
    xinc       = (x_major_q || minor_move) ? CoordW'(1) : '0;
    yinc       = (!x_major_q || minor_move) ? CoordW'(1) : '0;
    steps_nxt  = steps_q - CoordW'(1);
  end

  always_comb begin
    active_d     = active_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    dec_d        = dec_q;
    steps_d      = steps_q;
    minor_incr_d = minor_incr_q;
    diag_incr_d  = diag_incr_q;
    x_major_d    = x_major_q;
    x_neg_d      = x_neg_q;
    y_neg_d      = y_neg_q;
    color_d      = color_q;
    pend_valid_d = adv_i ? 1'b0 : pend_valid_q;
    pend_pix_d   = pend_pix_q;
    pend_last_d  = pend_last_q;
    if (accept) begin
      pend_valid_d = 1'b1;
      pend_pix_d   = 1'b0;
      pend_last_d  = 1'b0;
      if (req_i.cmd == CmdStart) begin
        color_d      = req_i.pen_color;
        x_neg_d      = ex[CoordW] && !axis;
        y_neg_d      = ey[CoordW] && !axis;
        x_major_d    = xmaj;
        minor_incr_d = mnr2;
        diag_incr_d  = mnr2 - {1'b0, maj, 1'b0};
        dec_d        = mnr2 - {2'b00, maj};
        steps_d      = maj;
        cur_x_d      = sx;
        cur_y_d      = sy;
        active_d     = maj != '0;
        pend_pix_d   = 1'b1;
        pend_last_d  = maj == '0;
      end else if ((req_i.cmd == CmdStep) && active_q) begin
        dec_d       = dec_q + (minor_move ? diag_incr_q : minor_incr_q);
        cur_x_d     = x_neg_q ? cur_x_q - $signed(xinc) : cur_x_q + $signed(xinc);
        cur_y_d     = y_neg_q ? cur_y_q - $signed(yinc) : cur_y_q + $signed(yinc);
        steps_d     = steps_nxt;
        active_d    = steps_nxt != '0;
        pend_pix_d  = 1'b1;
        pend_last_d = steps_nxt == '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      dec_q        <= '0;
      steps_q      <= '0;
      minor_incr_q <= '0;
      diag_incr_q  <= '0;
      x_major_q    <= 1'b0;
      x_neg_q      <= 1'b0;
      y_neg_q      <= 1'b0;
      color_q      <= '0;
      pend_valid_q <= 1'b0;
      pend_pix_q   <= 1'b0;
      pend_last_q  <= 1'b0;
    end else begin
      active_q     <= active_d;
      cur_x_q      <= cur_x_d;
      cur_y_q      <= cur_y_d;
      dec_q        <= dec_d;
      steps_q      <= steps_d;
      minor_incr_q <= minor_incr_d;
      diag_incr_q  <= diag_incr_d;
      x_major_q    <= x_major_d;
      x_neg_q      <= x_neg_d;
      y_neg_q      <= y_neg_d;
      color_q      <= color_d;
      pend_valid_q <= pend_valid_d;
      pend_pix_q   <= pend_pix_d;
      pend_last_q  <= pend_last_d;
    end
  end

  assign pend_o = '{valid: pend_valid_q, pix: pend_pix_q, last: pend_last_q,
                    x: cur_x_q, y: cur_y_q, color: color_q};

endmodule

`default_nettype wire

>>> hw/rtl/bresenham_line_pixel_gen.sv
// Line pixel generator top level: walker, screen clip, address/bank map, output register.
// Depends on blpg_pkg and blpg_walk.
//
// Usage:
// - Request channel (req_valid_i/req_ready_o/req_i): cmd start loads both endpoints and
//   the pen color and yields the first pixel; cmd step yields the next pixel. A step
//   with no line running yields one response with every field zero.
// - Response channel (rsp_valid_o/rsp_ready_i/rsp_o): exactly one response per request,
//   in request order, with clip flag, word address (row*1024 + column), 32K-word bank,
//   bank switch flag and last pixel flag.
// - Path: a request is held in the walker's pending register, then in the output register.
// - Throughput: one request per cycle while rsp_ready_i is high; each step is one add in
//   the walker, each pixel one address add and bank compare ahead of the output register.
// - Stall: with rsp_ready_i low, one more request still enters and waits between the
//   walker and the output register; after that req_ready_o stays low.
// - Reset: line state, pending pixel, output valid and bank history clear at once;
//   requests are taken in the first cycle after reset.
`default_nettype none

module bresenham_line_pixel_gen import blpg_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 1024,
  parameter int unsigned SCREEN_HEIGHT = 768
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      req_valid_i,
  output logic           req_ready_o,
  input  wire blpg_req_t req_i,
  output logic           rsp_valid_o,
  input  wire logic      rsp_ready_i,
  output blpg_rsp_t      rsp_o
);

  localparam logic [CoordW:0] ScrW = (CoordW+1)'(SCREEN_WIDTH);
  localparam logic [CoordW:0] ScrH = (CoordW+1)'(SCREEN_HEIGHT);

  blpg_pend_t       pend;
  logic             adv;
  logic             rsp_valid_q, rsp_valid_d;
  blpg_rsp_t        rsp_q, rsp_d;
  logic [BankW-1:0] last_bank_q, last_bank_d;
  logic             bank_known_q, bank_known_d;

  logic             vis;
  logic [AddrW-1:0] addr;
  logic [BankW-1:0] bk;
  logic             sw;

  blpg_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .adv_i       (adv),
    .pend_o      (pend)
  );

  assign adv = pend.valid && (!rsp_valid_q || rsp_ready_i);

  always_comb begin
    vis  = !pend.x[CoordW-1] && !pend.y[CoordW-1] &&
           ({1'b0, $unsigned(pend.x)} < ScrW) && ({1'b0, $unsigned(pend.y)} < ScrH);
    addr = (AddrW'($unsigned(pend.y)) << RowShift) + AddrW'($unsigned(pend.x));
    bk   = BankW'(addr >> BankShift);
    sw   = vis && (!bank_known_q || (bk != last_bank_q));

    rsp_d        = '0;
    last_bank_d  = last_bank_q;
    bank_known_d = bank_known_q;
    if (pend.pix) begin
      rsp_d.pixel_valid = 1'b1;
      rsp_d.pixel_x     = pend.x;
      rsp_d.pixel_y     = pend.y;
      rsp_d.pixel_color = pend.color;
      rsp_d.on_screen   = vis;
      rsp_d.last_pixel  = pend.last;
      if (vis) begin
        rsp_d.word_address = addr;
        rsp_d.bank         = bk;
        rsp_d.bank_switch  = sw;
        last_bank_d        = bk;
        bank_known_d       = 1'b1;
      end
    end
    rsp_valid_d = adv ? 1'b1 : (rsp_ready_i ? 1'b0 : rsp_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q  <= 1'b0;
      last_bank_q  <= '0;
      bank_known_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
      if (adv) begin
        last_bank_q  <= last_bank_d;
        bank_known_q <= bank_known_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

>>> hw/rtl/blpg_port_check.sv
// Port-level checker for the line pixel generator, bound to the top level.
// Depends on blpg_pkg and bresenham_line_pixel_gen_assert.svh.
`default_nettype none

`include "bresenham_line_pixel_gen_assert.svh"

module blpg_port_check import blpg_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      req_valid_i,
  input wire logic      req_ready_o,
  input wire blpg_req_t req_i,
  input wire logic      rsp_valid_o,
  input wire logic      rsp_ready_i,
  input wire blpg_rsp_t rsp_o
);

  logic req_fire;
  logic clip_zero;
  assign req_fire  = req_valid_i && req_ready_o;
  assign clip_zero = (rsp_o.word_address == '0) && (rsp_o.bank == '0) && !rsp_o.bank_switch;

  `BLPG_ASSERT_NEXT(a_rsp_hold, rsp_valid_o && !rsp_ready_i,
    rsp_valid_o && $stable(rsp_o), "response changed while stalled")
  `BLPG_ASSERT_NOW(a_idle_zero, rsp_valid_o && !rsp_o.pixel_valid,
    rsp_o == '0, "idle step response not all zero")
  `BLPG_ASSERT_NOW(a_clip_zero, rsp_valid_o && !rsp_o.on_screen,
    clip_zero, "clipped pixel carries an address")
  `BLPG_ASSERT_NOW(a_bank_map, rsp_valid_o && rsp_o.on_screen,
    rsp_o.bank == rsp_o.word_address[AddrW-1:BankShift], "bank does not match address")
  `BLPG_ASSERT_NOW(a_rsp_cause, $rose(rsp_valid_o),
    $past(req_fire, 2), "response without a request")

endmodule

bind bresenham_line_pixel_gen blpg_port_check u_port_check (.*);

`default_nettype wire
